// File: rtl/aavr_pkg.sv
package aavr_pkg;

  localparam int AXIS_BITS   = 16;
  localparam int ANGLE_BITS  = 19;
  localparam int TABLE_LEN   = 24;
  localparam int ZW          = 34;   // CORDIC angle width, Q30 plus sign and headroom
  localparam int XW          = 33;   // CORDIC x/y width, Q30 plus sign and headroom
  localparam int MW          = 29;   // matrix entry width, Q24

  localparam logic signed [ANGLE_BITS-1:0] ANGLE_LIMIT = 19'sd205887;
  localparam logic signed [ZW-1:0] HALF_PI_Q30 = 34'sd1686629713;
  localparam logic signed [ZW-1:0] PI_Q30      = 34'sd3373259426;

  // arctangent table, Q30
  function automatic logic signed [ZW-1:0] atan_q30(input int unsigned i);
    logic signed [ZW-1:0] r;
    r = '0;
    unique case (i)
      0:  r = 34'sd843314857;
      1:  r = 34'sd497837829;
      2:  r = 34'sd263043837;
      3:  r = 34'sd133525159;
      4:  r = 34'sd67021687;
      5:  r = 34'sd33543516;
      6:  r = 34'sd16775851;
      7:  r = 34'sd8388437;
      8:  r = 34'sd4194283;
      9:  r = 34'sd2097149;
      default: r = ZW'(64'sd1 << (30 - i));
    endcase
    return r;
  endfunction

  // CORDIC gain in Q30 (integer square root of the squared gain in Q60),
  // evaluated at elaboration
  function automatic logic [63:0] gain_root_q30(input int unsigned steps);
    logic [63:0] p, a, r, b;
    int unsigned n;
    p = 64'd1 << 60;
    n = (steps < TABLE_LEN) ? steps : TABLE_LEN;
    for (int unsigned i = 0; i < n; i++) p = p + (p >> (2 * i));
    a = p;
    r = '0;
    b = 64'd1 << 62;
    while (b > a) b = b >> 2;
    while (b != 0) begin
      if (a >= r + b) begin
        a = a - (r + b);
        r = (r >> 1) + b;
      end else begin
        r = r >> 1;
      end
      b = b >> 2;
    end
    return r;
  endfunction

endpackage

// File: rtl/axis_angle_vector_rotation.sv
// Axis-angle vector rotator. Each transfer carries a unit axis (Q1.14), a vector
// (Q8.15) and an angle (Q2.16, clamped to +/-pi) and returns the vector rotated
// by the axis-angle matrix, a right-handed rotation by minus the angle, with
// saturated Q8.15 results. The axis is not normalized. The pipeline takes one
// item per cycle while the output is not stalled. Stages: one input stage, one
// CORDIC stage per step, then sine/cosine products, matrix terms, vector
// products, and the sum/round/saturate output register. A stall freezes every
// stage at once.
module axis_angle_vector_rotation #(
  parameter int CORDIC_STEPS = 16,
  parameter int VECTOR_BITS  = 24
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          in_valid_i,
  output logic                          in_ready_o,
  input  logic signed [15:0]            axis_x_i,
  input  logic signed [15:0]            axis_y_i,
  input  logic signed [15:0]            axis_z_i,
  input  logic signed [VECTOR_BITS-1:0] vec_x_i,
  input  logic signed [VECTOR_BITS-1:0] vec_y_i,
  input  logic signed [VECTOR_BITS-1:0] vec_z_i,
  input  logic signed [18:0]            angle_i,
  output logic                          out_valid_o,
  input  logic                          out_ready_i,
  output logic signed [VECTOR_BITS-1:0] rot_x_o,
  output logic signed [VECTOR_BITS-1:0] rot_y_o,
  output logic signed [VECTOR_BITS-1:0] rot_z_o
);

  localparam int NS = (CORDIC_STEPS < aavr_pkg::TABLE_LEN) ? CORDIC_STEPS
                                                          : aavr_pkg::TABLE_LEN;
  localparam int XW = aavr_pkg::XW;
  localparam int ZW = aavr_pkg::ZW;
  localparam int MW = aavr_pkg::MW;
  localparam int VW = VECTOR_BITS;
  localparam int PW = MW + VW;           // one matrix-by-vector product
  localparam int SW = PW + 2;            // sum of three products
  localparam int NST = NS + 4;           // stages before the output register
  localparam logic [63:0] GAIN_ROOT = aavr_pkg::gain_root_q30(NS);
  localparam logic signed [XW-1:0] GAIN =
    XW'(((64'd1 << 60) + (GAIN_ROOT >> 1)) / GAIN_ROOT);

  typedef logic signed [15:0] axis_t;
  typedef logic signed [VW-1:0] vec_t;

  // global stall: advance only when the output register can take data
  logic adv;
  logic out_valid_q;
  assign adv        = !out_valid_q || out_ready_i;
  assign in_ready_o = adv;

  // valid bits per stage
  logic [NST-1:0] vld_q;

  // axis and vector ride along the stages up to their last use
  axis_t n_q [NS+1][3];
  vec_t  v_q [NS+3][3];

  // CORDIC stage registers; index 0 is the input stage
  logic signed [XW-1:0] cx_q [NS+1];
  logic signed [XW-1:0] cy_q [NS+1];
  logic signed [ZW-1:0] cz_q [NS+1];
  logic                 flip_q [NS+1];

  // input stage: clamp and reduce the angle
  logic signed [18:0]   ang_c;
  logic signed [ZW-1:0] z_w, z_r;
  logic                 flip_w;
  always_comb begin
    ang_c = angle_i;
    if (angle_i > aavr_pkg::ANGLE_LIMIT) ang_c = aavr_pkg::ANGLE_LIMIT;
    if (angle_i < -aavr_pkg::ANGLE_LIMIT) ang_c = -aavr_pkg::ANGLE_LIMIT;
    z_w    = ZW'(ang_c) <<< 14;
    z_r    = z_w;
    flip_w = 1'b0;
    if (z_w > aavr_pkg::HALF_PI_Q30) begin
      z_r    = z_w - aavr_pkg::PI_Q30;
      flip_w = 1'b1;
    end else if (z_w < -aavr_pkg::HALF_PI_Q30) begin
      z_r    = z_w + aavr_pkg::PI_Q30;
      flip_w = 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q       <= '0;
      out_valid_q <= 1'b0;
    end else if (adv) begin
      vld_q       <= {vld_q[NST-2:0], in_valid_i};
      out_valid_q <= vld_q[NST-1];
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      cx_q[0]   <= GAIN;
      cy_q[0]   <= '0;
      cz_q[0]   <= z_r;
      flip_q[0] <= flip_w;
      n_q[0][0] <= axis_x_i;
      n_q[0][1] <= axis_y_i;
      n_q[0][2] <= axis_z_i;
      v_q[0][0] <= vec_x_i;
      v_q[0][1] <= vec_y_i;
      v_q[0][2] <= vec_z_i;
    end
  end

  // pass axis and vector along
  for (genvar k = 1; k < NS + 3; k++) begin : g_carry
    always_ff @(posedge clk_i) begin
      if (adv) begin
        v_q[k] <= v_q[k-1];
        if (k <= NS) n_q[k] <= n_q[k-1];
      end
    end
  end

  // CORDIC rotation steps, one per stage
  for (genvar i = 0; i < NS; i++) begin : g_cordic
    always_ff @(posedge clk_i) begin
      if (adv) begin
        flip_q[i+1] <= flip_q[i];
        if (cz_q[i] >= 0) begin
          cx_q[i+1] <= cx_q[i] - (cy_q[i] >>> i);
          cy_q[i+1] <= cy_q[i] + (cx_q[i] >>> i);
          cz_q[i+1] <= cz_q[i] - aavr_pkg::atan_q30(i);
        end else begin
          cx_q[i+1] <= cx_q[i] + (cy_q[i] >>> i);
          cy_q[i+1] <= cy_q[i] - (cx_q[i] >>> i);
          cz_q[i+1] <= cz_q[i] + aavr_pkg::atan_q30(i);
        end
      end
    end
  end

  // sine/cosine products: n_i*sin, 1-cos, rounded cos, pairwise n_i*n_j
  logic signed [XW-1:0] sn_w, cs_w;
  assign sn_w = flip_q[NS] ? -cy_q[NS] : cy_q[NS];
  assign cs_w = flip_q[NS] ? -cx_q[NS] : cx_q[NS];

  logic signed [MW-1:0] ns_q [3];
  logic signed [MW-1:0] cq_q;
  logic signed [XW:0]   t_q;
  logic signed [32:0]   nn_q [3][3];
  always_ff @(posedge clk_i) begin
    if (adv) begin
      for (int a = 0; a < 3; a++) begin
        ns_q[a] <= MW'((50'(n_q[NS][a]) * 50'(sn_w) + (50'sd1 <<< 19)) >>> 20);
        for (int b = 0; b < 3; b++)
          nn_q[a][b] <= 33'(n_q[NS][a]) * 33'(n_q[NS][b]);
      end
      cq_q <= MW'((cs_w + XW'(32)) >>> 6);
      t_q  <= (XW+1)'(64'sd1 <<< 30) - (XW+1)'(cs_w);
    end
  end

  // matrix entries
  logic signed [MW-1:0] m_q [3][3];
  always_ff @(posedge clk_i) begin
    logic signed [MW-1:0] base [3][3];
    if (adv) begin
      for (int a = 0; a < 3; a++)
        for (int b = 0; b < 3; b++)
          base[a][b] = MW'((68'(nn_q[a][b]) * 68'(t_q) + (68'sd1 <<< 33)) >>> 34);
      m_q[0][0] <= base[0][0] + cq_q;
      m_q[1][1] <= base[1][1] + cq_q;
      m_q[2][2] <= base[2][2] + cq_q;
      m_q[0][1] <= base[0][1] + ns_q[2];
      m_q[0][2] <= base[0][2] - ns_q[1];
      m_q[1][0] <= base[1][0] - ns_q[2];
      m_q[1][2] <= base[1][2] + ns_q[0];
      m_q[2][0] <= base[2][0] + ns_q[1];
      m_q[2][1] <= base[2][1] - ns_q[0];
    end
  end

  // matrix-by-vector products
  logic signed [PW-1:0] p_q [3][3];
  always_ff @(posedge clk_i) begin
    if (adv) begin
      for (int a = 0; a < 3; a++)
        for (int b = 0; b < 3; b++)
          p_q[a][b] <= PW'(m_q[a][b]) * PW'(v_q[NS+2][b]);
    end
  end

  // sum, round and saturate into the output register
  localparam logic signed [SW-1:0] HI = SW'((64'sd1 <<< (VW - 1)) - 1);
  localparam logic signed [SW-1:0] LO = -SW'(64'sd1 <<< (VW - 1));
  vec_t rot_q [3];
  always_ff @(posedge clk_i) begin
    logic signed [SW-1:0] acc;
    if (adv) begin
      for (int a = 0; a < 3; a++) begin
        acc = SW'(p_q[a][0]) + SW'(p_q[a][1]) + SW'(p_q[a][2]);
        acc = (acc + (SW'(1) <<< 23)) >>> 24;
        if (acc > HI)      rot_q[a] <= HI[VW-1:0];
        else if (acc < LO) rot_q[a] <= LO[VW-1:0];
        else               rot_q[a] <= acc[VW-1:0];
      end
    end
  end

  assign out_valid_o = out_valid_q;
  assign rot_x_o     = rot_q[0];
  assign rot_y_o     = rot_q[1];
  assign rot_z_o     = rot_q[2];

endmodule

// File: test/axis_angle_vector_rotation_tb.sv
`timescale 1ns / 1ps

module axis_angle_vector_rotation_tb;

  localparam int STEPS   = 16;
  localparam int VB      = 24;
  localparam int LATENCY = STEPS + 5;
  localparam longint HALF_PI = 64'sd1686629713;
  localparam longint PI_VAL  = 64'sd3373259426;
  localparam int ALIM    = 205887;

  typedef struct packed {
    logic signed [15:0]   ax;
    logic signed [15:0]   ay;
    logic signed [15:0]   az;
    logic signed [VB-1:0] vx;
    logic signed [VB-1:0] vy;
    logic signed [VB-1:0] vz;
    logic signed [18:0]   ang;
  } rot_req_t;

  typedef struct packed {
    logic signed [VB-1:0] rx;
    logic signed [VB-1:0] ry;
    logic signed [VB-1:0] rz;
  } rot_res_t;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;
  logic in_valid_i = 1'b0;
  logic out_ready_i = 1'b0;
  logic in_ready_o, out_valid_o;
  logic signed [15:0] axis_x_i = '0, axis_y_i = '0, axis_z_i = '0;
  logic signed [VB-1:0] vec_x_i = '0, vec_y_i = '0, vec_z_i = '0;
  logic signed [18:0] angle_i = '0;
  logic signed [VB-1:0] rot_x_o, rot_y_o, rot_z_o;

  rot_res_t expected_rot_q[$];
  int err_count = 0;
  int send_idle_pct = 0;
  int recv_stall_pct = 0;
  int hold_off_cycles = 0;

  always #5 clk_i = ~clk_i;

  axis_angle_vector_rotation dut (
    .clk_i, .rst_ni, .in_valid_i, .in_ready_o,
    .axis_x_i, .axis_y_i, .axis_z_i, .vec_x_i, .vec_y_i, .vec_z_i, .angle_i,
    .out_valid_o, .out_ready_i, .rot_x_o, .rot_y_o, .rot_z_o
  );

  // floor shift and round-half-up shift on 64-bit values
  function automatic longint shr_floor(longint v, int s);
    return v >>> s;
  endfunction

  function automatic longint shr_round(longint v, int s);
    return (v + (64'sd1 << (s - 1))) >>> s;
  endfunction

  function automatic longint clamp_vec(longint v);
    longint hi, lo;
    hi = (64'sd1 <<< (VB - 1)) - 1;
    lo = -(64'sd1 <<< (VB - 1));
    return v > hi ? hi : (v < lo ? lo : v);
  endfunction

  // inverse CORDIC gain, Q30, exact integer square root
  function automatic longint cordic_gain_inv();
    longint unsigned p, a, r, b;
    p = 64'd1 << 60;
    for (int i = 0; i < STEPS; i++) p = p + (p >> (2 * i));
    a = p; r = 0; b = 64'd1 << 62;
    while (b > a) b = b >> 2;
    while (b != 0) begin
      if (a >= r + b) begin
        a = a - (r + b);
        r = (r >> 1) + b;
      end else begin
        r = r >> 1;
      end
      b = b >> 2;
    end
    return longint'(((64'd1 << 60) + (r >> 1)) / r);
  endfunction

  function automatic longint atan_entry(int i);
    longint tbl[10];
    tbl = '{843314857, 497837829, 263043837, 133525159, 67021687,
            33543516, 16775851, 8388437, 4194283, 2097149};
    return (i < 10) ? tbl[i] : (64'sd1 <<< (30 - i));
  endfunction

  // expected rotated vector for one request
  function automatic rot_res_t rotate_vec(rot_req_t r);
    longint n[3], v[3], a, z, x, y, nx, sn, cs, t, cq, ns[3], m[3][3], acc;
    logic flip;
    rot_res_t res;
    n[0] = r.ax; n[1] = r.ay; n[2] = r.az;
    v[0] = r.vx; v[1] = r.vy; v[2] = r.vz;
    a = r.ang;
    if (a > ALIM) a = ALIM;
    if (a < -ALIM) a = -ALIM;
    z = a * 16384;
    x = cordic_gain_inv();
    y = 0;
    flip = 1'b0;
    if (z > HALF_PI) begin
      z -= PI_VAL; flip = 1'b1;
    end else if (z < -HALF_PI) begin
      z += PI_VAL; flip = 1'b1;
    end
    for (int i = 0; i < STEPS; i++) begin
      if (z >= 0) begin
        nx = x - shr_floor(y, i); y = y + shr_floor(x, i); z -= atan_entry(i);
      end else begin
        nx = x + shr_floor(y, i); y = y - shr_floor(x, i); z += atan_entry(i);
      end
      x = nx;
    end
    sn = flip ? -y : y;
    cs = flip ? -x : x;
    t = (64'sd1 << 30) - cs;
    cq = shr_round(cs, 6);
    for (int i = 0; i < 3; i++) ns[i] = shr_round(n[i] * sn, 20);
    for (int i = 0; i < 3; i++)
      for (int j = 0; j < 3; j++) m[i][j] = shr_round(n[i] * n[j] * t, 34);
    m[0][0] += cq; m[1][1] += cq; m[2][2] += cq;
    m[0][1] += ns[2]; m[0][2] -= ns[1];
    m[1][0] -= ns[2]; m[1][2] += ns[0];
    m[2][0] += ns[1]; m[2][1] -= ns[0];
    for (int i = 0; i < 3; i++) begin
      acc = m[i][0] * v[0] + m[i][1] * v[1] + m[i][2] * v[2];
      acc = clamp_vec(shr_round(acc, 24));
      if (i == 0) res.rx = acc[VB-1:0];
      else if (i == 1) res.ry = acc[VB-1:0];
      else res.rz = acc[VB-1:0];
    end
    return res;
  endfunction

  task automatic report_mismatch(string what, longint got, longint want);
    $display("mismatch %s: got %0d expected %0d", what, got, want);
    err_count++;
  endtask

  // offer one request, hold it until the transfer; drop valid only while idling
  task automatic send_rotation(rot_req_t r);
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid_i <= 1'b0;
      @(posedge clk_i);
    end
    in_valid_i <= 1'b1;
    axis_x_i <= r.ax; axis_y_i <= r.ay; axis_z_i <= r.az;
    vec_x_i <= r.vx; vec_y_i <= r.vy; vec_z_i <= r.vz;
    angle_i <= r.ang;
    expected_rot_q.push_back(rotate_vec(r));
    @(posedge clk_i);
    while (!in_ready_o) @(posedge clk_i);
  endtask

  // drive receiver ready, honoring a long hold-off when requested
  always @(posedge clk_i) begin
    if (hold_off_cycles > 0) begin
      hold_off_cycles <= hold_off_cycles - 1;
      out_ready_i <= 1'b0;
    end else begin
      out_ready_i <= ($urandom_range(99) >= recv_stall_pct);
    end
  end

  // check each result transfer against the oldest expectation
  always @(posedge clk_i) begin
    rot_res_t want;
    if (rst_ni && out_valid_o && out_ready_i) begin
      if (expected_rot_q.size() == 0) begin
        report_mismatch("unexpected result", rot_x_o, 0);
      end else begin
        want = expected_rot_q.pop_front();
        if (rot_x_o !== want.rx) report_mismatch("rot_x", rot_x_o, want.rx);
        if (rot_y_o !== want.ry) report_mismatch("rot_y", rot_y_o, want.ry);
        if (rot_z_o !== want.rz) report_mismatch("rot_z", rot_z_o, want.rz);
      end
    end
  end

  function automatic rot_req_t random_req();
    rot_req_t r;
    int k;
    k = $urandom_range(9);
    // unit axes, random axes of norm at most one, or arbitrary ones
    if (k < 3) begin
      r.ax = 0; r.ay = 0; r.az = 0;
      case ($urandom_range(2))
        0: r.ax = $urandom_range(1) ? 16'sd16384 : -16'sd16384;
        1: r.ay = $urandom_range(1) ? 16'sd16384 : -16'sd16384;
        default: r.az = $urandom_range(1) ? 16'sd16384 : -16'sd16384;
      endcase
    end else if (k < 6) begin
      r.ax = 16'($signed($urandom_range(18918)) - 9459);
      r.ay = 16'($signed($urandom_range(18918)) - 9459);
      r.az = 16'($signed($urandom_range(18918)) - 9459);
    end else begin
      r.ax = 16'($urandom); r.ay = 16'($urandom); r.az = 16'($urandom);
    end
    if ($urandom_range(3) == 0) begin
      r.vx = VB'($urandom); r.vy = VB'($urandom); r.vz = VB'($urandom);
    end else begin
      r.vx = VB'($signed($urandom_range(65535)) - 32768);
      r.vy = VB'($signed($urandom_range(65535)) - 32768);
      r.vz = VB'($signed($urandom_range(65535)) - 32768);
    end
    if ($urandom_range(9) == 0) r.ang = 19'($urandom);
    else r.ang = 19'($signed($urandom_range(2 * ALIM)) - ALIM);
    return r;
  endfunction

  // drop valid and wait for every expected result
  task automatic wait_drained();
    in_valid_i <= 1'b0;
    while (expected_rot_q.size() != 0) @(posedge clk_i);
  endtask

  task automatic test_directed();
    rot_req_t r;
    int angs[10];
    angs = '{0, 1, -1, 102943, -102944, 205887, -205887, 262143, -262144, 51472};
    for (int i = 0; i < 10; i++) begin
      r = '{16384, 0, 0, 32768, -32768, 12345, 19'(angs[i])};
      r.ax = (i % 3 == 0) ? 16384 : 0;
      r.ay = (i % 3 == 1) ? -16384 : 0;
      r.az = (i % 3 == 2) ? 16384 : 0;
      send_rotation(r);
    end
    // extremes of the vector and axis fields, saturation
    send_rotation('{16384, 16384, 16384, 8388607, 8388607, 8388607, 100000});
    send_rotation('{-16384, -16384, -16384, -8388608, -8388608, -8388608, -100000});
    send_rotation('{32767, -32768, 32767, 8388607, -8388608, 8388607, 205887});
    send_rotation('{-32768, 32767, -32768, -8388608, 8388607, 0, 0});
    send_rotation('{0, 0, 0, 8388607, -8388608, -1, 150000});
    send_rotation('{9459, 9459, 9459, -1, 1, 0, -205887});
    wait_drained();
  endtask

  task automatic test_random_phase(int idle, int stall, int count);
    send_idle_pct = idle;
    recv_stall_pct = stall;
    for (int i = 0; i < count; i++) send_rotation(random_req());
  endtask

  // hold the receiver off long enough to back the pipeline up
  task automatic test_backpressure();
    send_idle_pct = 0;
    recv_stall_pct = 0;
    hold_off_cycles = 4 * LATENCY;
    for (int i = 0; i < 3 * LATENCY; i++) send_rotation(random_req());
    wait_drained();
  endtask

  initial begin
    repeat (3) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    test_directed();
    test_random_phase(0, 0, 250);
    test_random_phase(53, 0, 200);
    test_random_phase(0, 53, 200);
    test_random_phase(28, 28, 150);
    wait_drained();
    test_backpressure();
    test_random_phase(0, 0, 150);
    wait_drained();
    recv_stall_pct = 0;
    repeat (LATENCY + 4) @(posedge clk_i);
    if (err_count == 0 && expected_rot_q.size() == 0) begin
      $display("** axis_angle_vector_rotation: PASSED **");
    end else begin
      $display("** axis_angle_vector_rotation: FAILED **");
    end
    $finish;
  end

  initial begin
    #2_000_000;
    $display("** axis_angle_vector_rotation: FAILED **");
    $finish;
  end

endmodule
